// ===== hdl/sbph_pkg.sv =====
// ----------------------------------------------------------------------------
// sbph_pkg
// Shared widths and constants for the segment versus box projected hit unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sbph_pkg;

	// coordinate width in use (low bits of each field, sign extended)
	localparam int CW        = 32;
	// field widths on the ports
	localparam int CRD_BITS  = 32;
	localparam int HALF_BITS = 31;
	localparam int N_CRD     = 9;
	localparam int N_HALF    = 3;
	localparam int IN_BITS   = N_CRD * CRD_BITS + N_HALF * HALF_BITS;
	localparam int IN_BYTES  = (IN_BITS + 7) / 8;
	localparam int IN_TDATA  = IN_BYTES * 8;
	localparam int OUT_TDATA = 8;
	localparam int HALF_BASE = N_CRD * CRD_BITS;

	// internal widths
	localparam int BW = CW + 1;          // box bounds, deltas
	localparam int DW = CW + 2;          // differences against a bound
	localparam int PW = BW + DW;         // exact products
	localparam int SW = PW + 1;          // product differences

	localparam int N_AX = 3;
	localparam int N_PL = 3;

	typedef logic signed [CW-1:0] crd_t;
	typedef logic signed [BW-1:0] bnd_t;
	typedef logic signed [DW-1:0] ext_t;
	typedef logic signed [PW-1:0] prd_t;
	typedef logic signed [SW-1:0] dif_t;

	// plane axes: XY, ZY, XZ (horizontal axis first)
	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;
	localparam int PL_H [N_PL] = '{AX_X, AX_Z, AX_X};
	localparam int PL_V [N_PL] = '{AX_Y, AX_Y, AX_Z};

endpackage : sbph_pkg

`default_nettype wire

// ===== hdl/segment_box_projected_hit_unit.sv =====
// ----------------------------------------------------------------------------
// segment_box_projected_hit_unit
// Segment versus axis-aligned box test by projection onto XY, ZY and XZ.
// ----------------------------------------------------------------------------
// Pipeline: four register stages, the first loaded at the edge that accepts an
//   input item; the result on m_tvalid comes from the fourth.
// Throughput: one item per cycle while the output is not stalled; the widest
//   stage holds the 33 x 34 bit products of the edge side tests.
// Backpressure stalls all stages together; nothing is lost or repeated.
// Reset (arst_n low, asynchronous) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_box_projected_hit_unit
	import sbph_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	// low bit up: seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y,
	// seg_end_z, box_center_x, box_center_y, box_center_z (32 bits each),
	// box_half_x, box_half_y, box_half_z (31 bits each), 3 zero pad bits
	input  wire logic [sbph_pkg::IN_TDATA-1:0]  s_tdata,
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	// low bit up: hit, 7 zero pad bits
	output      logic [sbph_pkg::OUT_TDATA-1:0] m_tdata
);

	// Both entries nonzero and of opposite sign: a strict side change.
	function automatic logic opp(input dif_t a, input dif_t b);
		logic nz;
		nz = (a != '0) && (b != '0);
		return nz && (a[SW-1] != b[SW-1]);
	endfunction

	// One enable for the whole pipe: advance when the output slot is free
	// or being emptied this cycle.
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ------------------------------------------------------------------
	// Stage 1: unpack, sign extend, form box bounds per axis.
	// ------------------------------------------------------------------
	crd_t st_c [N_AX];
	crd_t en_c [N_AX];
	bnd_t lo_c [N_AX];
	bnd_t hi_c [N_AX];
	logic hnz_c[N_AX];

	always_comb begin
		for (int a = 0; a < N_AX; a++) begin
			crd_t                ctr;
			logic [CW-2:0]       hf;
			st_c[a]  = crd_t'(s_tdata[a*CRD_BITS +: CW]);
			en_c[a]  = crd_t'(s_tdata[(a+3)*CRD_BITS +: CW]);
			ctr      = crd_t'(s_tdata[(a+6)*CRD_BITS +: CW]);
			hf       = s_tdata[HALF_BASE + a*HALF_BITS +: CW-1];
			lo_c[a]  = bnd_t'(ctr) - $signed({2'b00, hf});
			hi_c[a]  = bnd_t'(ctr) + $signed({2'b00, hf});
			hnz_c[a] = (hf != '0);
		end
	end

	logic vld_s1;
	crd_t st_s1 [N_AX];
	crd_t en_s1 [N_AX];
	bnd_t lo_s1 [N_AX];
	bnd_t hi_s1 [N_AX];
	logic hnz_s1[N_AX];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1  <= st_c;
			en_s1  <= en_c;
			lo_s1  <= lo_c;
			hi_s1  <= hi_c;
			hnz_s1 <= hnz_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: per plane, the four shared products and the comparisons.
	// The rectangle edges are axis aligned, so every side test reduces to
	// dx*(bound_v - s_v) against dy*(bound_h - s_h), and the tests of the
	// segment endpoints against an edge reduce to plain compares.
	// ------------------------------------------------------------------
	logic vld_s2;
	logic vld_s3;
	logic pl_s3 [N_PL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	for (genvar p = 0; p < N_PL; p++) begin : g_pl
		localparam int H = PL_H[p];
		localparam int V = PL_V[p];

		ext_t sh, sv, eh, ev, lh, rh, bv, tv;
		bnd_t dx, dy;
		ext_t tmsv, bmsv, lmsh, rmsh;
		prd_t pt_c, pb_c, ql_c, qr_c;
		logic inb_c, ct_c, cb_c, cl_c, cr_c;

		always_comb begin
			sh   = ext_t'(st_s1[H]);
			sv   = ext_t'(st_s1[V]);
			eh   = ext_t'(en_s1[H]);
			ev   = ext_t'(en_s1[V]);
			lh   = ext_t'(lo_s1[H]);
			rh   = ext_t'(hi_s1[H]);
			bv   = ext_t'(lo_s1[V]);
			tv   = ext_t'(hi_s1[V]);
			dx   = bnd_t'(en_s1[H]) - bnd_t'(st_s1[H]);
			dy   = bnd_t'(en_s1[V]) - bnd_t'(st_s1[V]);
			tmsv = tv - sv;
			bmsv = bv - sv;
			lmsh = lh - sh;
			rmsh = rh - sh;
			pt_c = prd_t'(dx) * prd_t'(tmsv);
			pb_c = prd_t'(dx) * prd_t'(bmsv);
			ql_c = prd_t'(dy) * prd_t'(lmsh);
			qr_c = prd_t'(dy) * prd_t'(rmsh);
			inb_c = (sh >= lh) && (sh <= rh) && (sv >= bv) && (sv <= tv) &&
			        (eh >= lh) && (eh <= rh) && (ev >= bv) && (ev <= tv);
			// endpoints strictly on opposite sides of the edge line, and the
			// edge itself of nonzero length
			ct_c = hnz_s1[H] && (((sv < tv) && (ev > tv)) || ((sv > tv) && (ev < tv)));
			cb_c = hnz_s1[H] && (((sv < bv) && (ev > bv)) || ((sv > bv) && (ev < bv)));
			cl_c = hnz_s1[V] && (((sh < lh) && (eh > lh)) || ((sh > lh) && (eh < lh)));
			cr_c = hnz_s1[V] && (((sh < rh) && (eh > rh)) || ((sh > rh) && (eh < rh)));
		end

		prd_t pt_s2, pb_s2, ql_s2, qr_s2;
		logic inb_s2, ct_s2, cb_s2, cl_s2, cr_s2;

		always_ff @(posedge clk) begin
			if (adv) begin
				pt_s2  <= pt_c;
				pb_s2  <= pb_c;
				ql_s2  <= ql_c;
				qr_s2  <= qr_c;
				inb_s2 <= inb_c;
				ct_s2  <= ct_c;
				cb_s2  <= cb_c;
				cl_s2  <= cl_c;
				cr_s2  <= cr_c;
			end
		end

		// --------------------------------------------------------------
		// Stage 3: side signs of the rectangle corners, plane verdict.
		// --------------------------------------------------------------
		dif_t d_tl, d_tr, d_bl, d_br;
		logic hit_c;

		always_comb begin
			d_tl  = dif_t'(pt_s2) - dif_t'(ql_s2);
			d_tr  = dif_t'(pt_s2) - dif_t'(qr_s2);
			d_bl  = dif_t'(pb_s2) - dif_t'(ql_s2);
			d_br  = dif_t'(pb_s2) - dif_t'(qr_s2);
			hit_c = inb_s2 ||
			        (ct_s2 && opp(d_tl, d_tr)) ||
			        (cb_s2 && opp(d_bl, d_br)) ||
			        (cl_s2 && opp(d_tl, d_bl)) ||
			        (cr_s2 && opp(d_tr, d_br));
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pl_s3[p] <= hit_c;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: combine the planes into the output register.
	// ------------------------------------------------------------------
	logic vld_s4;
	logic hit_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s4 <= pl_s3[0] && pl_s3[1] && pl_s3[2];
		end
	end

	assign m_tvalid = vld_s4;
	assign m_tdata  = {{(OUT_TDATA-1){1'b0}}, hit_s4};

endmodule : segment_box_projected_hit_unit

`default_nettype wire
